### hdl/gnb_pkg.sv
// shared types, constants and helper functions for the gaussian noise block
`default_nettype none
package gnb_pkg;

   // fixed formats
   localparam int SampleFracBits = 12;
   localparam int RoundShift     = 24 - SampleFracBits;
   localparam int LogSteps       = 24;
   localparam int SqrtSteps      = 28;
   localparam int RotSteps       = 20;

   // generator and math constants
   localparam logic [31:0] LCG_MUL     = 32'd1664525;
   localparam logic [31:0] LCG_INC     = 32'd1013904223;
   localparam logic [29:0] T_MAX_Q24   = 30'd390128936;
   localparam logic [31:0] LN2_Q32     = 32'hB17217F7;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [29:0] INV_GAIN    = 30'd652032874;

   // rounding offset, one half of the output lsb in q24
   localparam logic signed [32:0] ROUND_HALF = 33'(1) << (RoundShift - 1);

   // register indexes of the csr port
   localparam logic CSR_SEED  = 1'b0;
   localparam logic CSR_COUNT = 1'b1;

   // one drawn pair with its run flags
   typedef struct packed {
      logic [24:0] v;
      logic [24:0] p;
      logic        second_valid;
      logic        last;
   } gnb_item_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DRAW2,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_LOG,
      B_LN,
      B_SQRT,
      B_GAIN,
      B_ROT,
      B_DONE
   } back_state_type;

   // one lcg step, modulo 2^32
   function automatic logic [31:0] lcg_next(input logic [31:0] s);
      logic [31:0] prod;
      prod = s * LCG_MUL;
      return prod + LCG_INC;
   endfunction

   // arctangent table, q30 radians
   function automatic logic [31:0] atan_q30(input logic [4:0] i);
      logic [31:0] a;
      case (i)
         5'd0:    a = 32'h3243F6A8;
         5'd1:    a = 32'h1DAC6705;
         5'd2:    a = 32'h0FADBAFC;
         5'd3:    a = 32'h07F56EA6;
         5'd4:    a = 32'h03FEAB76;
         5'd5:    a = 32'h01FFD55B;
         5'd6:    a = 32'h00FFFAAA;
         5'd7:    a = 32'h007FFF55;
         5'd8:    a = 32'h003FFFEA;
         5'd9:    a = 32'h001FFFFD;
         5'd10:   a = 32'h000FFFFF;
         5'd11:   a = 32'h0007FFFF;
         5'd12:   a = 32'h0003FFFF;
         5'd13:   a = 32'h0001FFFF;
         5'd14:   a = 32'h0000FFFF;
         5'd15:   a = 32'h00007FFF;
         5'd16:   a = 32'h00003FFF;
         5'd17:   a = 32'h00001FFF;
         5'd18:   a = 32'h00000FFF;
         5'd19:   a = 32'h000007FF;
         default: a = 32'h0;
      endcase
      return a;
   endfunction

   // round half up from q24 and saturate to 16 bits
   function automatic logic signed [15:0] to_sample(input logic signed [31:0] val);
      logic signed [32:0] sum;
      logic signed [32:0] shr;
      logic signed [15:0] res;
      sum = {val[31], val} + ROUND_HALF;
      shr = sum >>> RoundShift;
      if (shr > 33'sd32767)
         res = 16'sh7fff;
      else if (shr < -33'sd32768)
         res = 16'sh8000;
      else
         res = shr[15:0];
      return res;
   endfunction

endpackage
`default_nettype wire

### hdl/gnb_front.sv
// front end: accepts requests, runs the lcg and computes the run flags
`default_nettype none
module gnb_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire logic                 reseed,
   output logic                      full,
   input  wire logic [31:0]          seed,
   input  wire logic [24:0]          count,
   output logic                      q_push,
   output gnb_pkg::gnb_item_type     q_item,
   input  wire logic                 q_full
);
   import gnb_pkg::*;

   front_state_type state_ff, state_in;
   logic [31:0] lcg_ff, lcg_in;
   logic [24:0] idx_ff, idx_in;
   logic [24:0] v_ff, v_in, p_ff, p_in;
   logic        sv_ff, sv_in, last_ff, last_in;
   logic        accept;
   logic [31:0] seed_sel, mul_src, word;
   logic [24:0] cnt_eff, idx_cur;
   logic [25:0] idx_p1, idx_p2;

   assign accept = push && (state_ff == F_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE:  if (accept) state_in = F_DRAW2;
         F_DRAW2: state_in = F_PUSH;
         F_PUSH:  if (!q_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      full   = (state_ff != F_IDLE);
      q_push = (state_ff == F_PUSH) && !q_full;
      q_item = '{v: v_ff, p: p_ff, second_valid: sv_ff, last: last_ff};
   end

   // lcg draw and index bookkeeping
   always_comb begin
      seed_sel = (seed == 32'd0) ? 32'd1 : seed;
      mul_src  = ((state_ff == F_IDLE) && reseed) ? seed_sel : lcg_ff;
      word     = lcg_next(mul_src);
      cnt_eff  = (count == 25'd0) ? 25'd1 : count;
      idx_cur  = reseed ? 25'd0 : idx_ff;
      idx_p1   = {1'b0, idx_cur} + 26'd1;
      idx_p2   = {1'b0, idx_cur} + 26'd2;
      lcg_in   = lcg_ff;
      idx_in   = idx_ff;
      v_in     = v_ff;
      p_in     = p_ff;
      sv_in    = sv_ff;
      last_in  = last_ff;
      if (accept) begin
         lcg_in  = word;
         v_in    = {word[31:8], 1'b1};
         sv_in   = idx_p1 < {1'b0, cnt_eff};
         last_in = idx_p2 >= {1'b0, cnt_eff};
         idx_in  = (idx_p2 >= {1'b0, cnt_eff}) ? 25'd0 : idx_p2[24:0];
      end else if (state_ff == F_DRAW2) begin
         lcg_in = word;
         p_in   = {word[31:8], 1'b1};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         lcg_ff   <= 32'd1;
         idx_ff   <= 25'd0;
      end else begin
         state_ff <= state_in;
         lcg_ff   <= lcg_in;
         idx_ff   <= idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      p_ff    <= p_in;
      sv_ff   <= sv_in;
      last_ff <= last_in;
   end

endmodule
`default_nettype wire

### hdl/gnb_queue.sv
// two-entry queue between front end and math back end
`default_nettype none
module gnb_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire gnb_pkg::gnb_item_type push_item,
   output logic                  full,
   input  wire logic             pop,
   output gnb_pkg::gnb_item_type pop_item,
   output logic                  empty
);
   import gnb_pkg::*;

   gnb_item_type slot_ff [2];
   logic         wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]   fill_ff, fill_in;

   // pointers and fill level
   always_comb begin
      wr_in   = push ? ~wr_ff : wr_ff;
      rd_in   = pop ? ~rd_ff : rd_ff;
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
      full    = (fill_ff == 2'd2);
      empty   = (fill_ff == 2'd0);
      pop_item = slot_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_item;
   end

endmodule
`default_nettype wire

### hdl/gnb_back.sv
// back end: iterative log, square root and cordic, with result register
`default_nettype none
module gnb_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_empty,
   input  wire gnb_pkg::gnb_item_type q_item,
   output logic                       q_pop,
   input  wire logic                  rsp_pop,
   output logic                       rsp_empty,
   output logic signed [15:0]         sample_first,
   output logic signed [15:0]         sample_second,
   output logic                       second_valid,
   output logic                       last
);
   import gnb_pkg::*;

   back_state_type state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [30:0] mant_ff, mant_in;
   logic [4:0]  e_ff, e_in;
   logic [23:0] frac_ff, frac_in;
   logic [1:0]  quad_ff, quad_in;
   logic signed [32:0] z_ff, z_in;
   logic        sv_ff, sv_in, lst_ff, lst_in;
   logic [55:0] n_ff, n_in, res_ff, res_in, bit_ff, bit_in;
   logic signed [31:0] cx_ff, cx_in, cy_ff, cy_in;
   logic        out_valid_ff, out_valid_in;
   logic signed [15:0] first_ff, first_in, second_ff, second_in;
   logic        osv_ff, osv_in, olast_ff, olast_in;
   logic        out_load, out_take, step_end;

   logic [4:0]  e_find;
   logic [53:0] zprod;
   logic [61:0] sq;
   logic [31:0] sq_sh;
   logic [29:0] t_raw;
   logic [28:0] t_clamp;
   logic [60:0] lprod;
   logic [55:0] trial;
   logic [57:0] gprod;
   logic signed [32:0] atan_s;
   logic signed [31:0] ca, sa;

   assign out_take = out_valid_ff && rsp_pop;
   assign out_load = (state_ff == B_DONE) && (!out_valid_ff || rsp_pop);

   // last iteration of the running loop
   always_comb begin
      case (state_ff)
         B_LOG:   step_end = (cnt_ff == 5'(LogSteps - 1));
         B_SQRT:  step_end = (cnt_ff == 5'(SqrtSteps - 1));
         B_ROT:   step_end = (cnt_ff == 5'(RotSteps - 1));
         default: step_end = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE:  if (!q_empty) state_in = B_LOG;
         B_LOG:   if (step_end) state_in = B_LN;
         B_LN:    state_in = B_SQRT;
         B_SQRT:  if (step_end) state_in = B_GAIN;
         B_GAIN:  state_in = B_ROT;
         B_ROT:   if (step_end) state_in = B_DONE;
         B_DONE:  if (out_load) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      q_pop         = (state_ff == B_IDLE) && !q_empty;
      rsp_empty     = !out_valid_ff;
      sample_first  = first_ff;
      sample_second = second_ff;
      second_valid  = osv_ff;
      last          = olast_ff;
   end

   // datapath
   always_comb begin
      // top set bit of v
      e_find = 5'd0;
      for (int k = 1; k < 25; k++) begin
         if (q_item.v[k]) e_find = 5'(k);
      end
      zprod   = q_item.p[22:0] * HALF_PI_Q30;
      sq      = mant_ff * mant_ff;
      sq_sh   = sq[61:30];
      t_raw   = {5'd25, 24'd0} - {1'b0, e_ff, frac_ff};
      t_clamp = (t_raw > T_MAX_Q24) ? T_MAX_Q24[28:0] : t_raw[28:0];
      lprod   = t_clamp * LN2_Q32;
      trial   = res_ff + bit_ff;
      gprod   = res_ff[27:0] * INV_GAIN;
      atan_s  = $signed({1'b0, atan_q30(cnt_ff)});

      // quadrant mapping
      case (quad_ff)
         2'd0:    begin ca = cx_ff;  sa = cy_ff;  end
         2'd1:    begin ca = -cy_ff; sa = cx_ff;  end
         2'd2:    begin ca = -cx_ff; sa = -cy_ff; end
         default: begin ca = cy_ff;  sa = -cx_ff; end
      endcase

      cnt_in   = cnt_ff;
      mant_in  = mant_ff;
      e_in     = e_ff;
      frac_in  = frac_ff;
      quad_in  = quad_ff;
      z_in     = z_ff;
      sv_in    = sv_ff;
      lst_in   = lst_ff;
      n_in     = n_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;

      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               e_in    = e_find;
               mant_in = 31'({6'd0, q_item.v} << (5'd30 - e_find));
               frac_in = 24'd0;
               quad_in = q_item.p[24:23];
               z_in    = {2'b00, zprod[53:23]};
               sv_in   = q_item.second_valid;
               lst_in  = q_item.last;
               cnt_in  = 5'd0;
            end
         end
         // one fraction bit of log2 by squaring
         B_LOG: begin
            if (sq_sh[31]) begin
               mant_in = sq_sh[31:1];
               frac_in = {frac_ff[22:0], 1'b1};
            end else begin
               mant_in = sq_sh[30:0];
               frac_in = {frac_ff[22:0], 1'b0};
            end
            cnt_in = step_end ? 5'd0 : cnt_ff + 5'd1;
         end
         // clamp and scale to -2 ln u1, set up the root
         B_LN: begin
            n_in   = {2'b00, lprod[60:31], 24'd0};
            res_in = 56'd0;
            bit_in = 56'd1 << 54;
            cnt_in = 5'd0;
         end
         // one root digit
         B_SQRT: begin
            if (n_ff >= trial) begin
               n_in   = n_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = step_end ? 5'd0 : cnt_ff + 5'd1;
         end
         // radius with cordic gain folded in
         B_GAIN: begin
            cx_in  = $signed({4'd0, gprod[57:30]});
            cy_in  = 32'sd0;
            cnt_in = 5'd0;
         end
         // one cordic rotation
         B_ROT: begin
            if (!z_ff[32]) begin
               cx_in = cx_ff - (cy_ff >>> cnt_ff);
               cy_in = cy_ff + (cx_ff >>> cnt_ff);
               z_in  = z_ff - atan_s;
            end else begin
               cx_in = cx_ff + (cy_ff >>> cnt_ff);
               cy_in = cy_ff - (cx_ff >>> cnt_ff);
               z_in  = z_ff + atan_s;
            end
            cnt_in = step_end ? 5'd0 : cnt_ff + 5'd1;
         end
         default: ;
      endcase

      // result register
      out_valid_in = out_load ? 1'b1 : (out_take ? 1'b0 : out_valid_ff);
      first_in     = out_load ? to_sample(ca) : first_ff;
      second_in    = out_load ? to_sample(sa) : second_ff;
      osv_in       = out_load ? sv_ff : osv_ff;
      olast_in     = out_load ? lst_ff : olast_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         cnt_ff       <= 5'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mant_ff   <= mant_in;
      e_ff      <= e_in;
      frac_ff   <= frac_in;
      quad_ff   <= quad_in;
      z_ff      <= z_in;
      sv_ff     <= sv_in;
      lst_ff    <= lst_in;
      n_ff      <= n_in;
      res_ff    <= res_in;
      bit_ff    <= bit_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      osv_ff    <= osv_in;
      olast_ff  <= olast_in;
   end

endmodule
`default_nettype wire

### hdl/gaussian_noise_box_muller_lcg.sv
// top level: csr registers, front end, queue and math back end
// the back end works on one pair at a time in the shared iterative unit
//   (24 log steps, 28 root steps, 20 cordic rotations, plus the idle, ln, gain and done
//   states) and takes the next pair only after loading the result register
// the front end takes a new request only after the previous one is pushed to the queue
// synchronous reset: seed 1, sample count 32, generator state 1, index 0, no result
`default_nettype none
module gaussian_noise_box_muller_lcg (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic               req_reseed,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic signed [15:0]      rsp_sample_first,
   output logic signed [15:0]      rsp_sample_second,
   output logic                    rsp_second_valid,
   output logic                    rsp_last,
   input  wire logic               csr_wr_en,
   input  wire logic               csr_index,
   input  wire logic [31:0]        csr_wr_data
);
   import gnb_pkg::*;

   logic [31:0]  seed_ff, seed_in;
   logic [24:0]  count_ff, count_in;
   logic         qi_push, qi_full, qo_pop, qo_empty;
   gnb_item_type qi_item, qo_item;

   // csr writes
   always_comb begin
      seed_in  = seed_ff;
      count_in = count_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SEED:  seed_in  = csr_wr_data;
            CSR_COUNT: count_in = csr_wr_data[24:0];
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= 32'd1;
         count_ff <= 25'd32;
      end else begin
         seed_ff  <= seed_in;
         count_ff <= count_in;
      end
   end

   gnb_front u_front (
      .clock  (clock),
      .reset  (reset),
      .push   (req_push),
      .reseed (req_reseed),
      .full   (req_full),
      .seed   (seed_ff),
      .count  (count_ff),
      .q_push (qi_push),
      .q_item (qi_item),
      .q_full (qi_full)
   );

   gnb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (qi_push),
      .push_item (qi_item),
      .full      (qi_full),
      .pop       (qo_pop),
      .pop_item  (qo_item),
      .empty     (qo_empty)
   );

   gnb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (qo_empty),
      .q_item        (qo_item),
      .q_pop         (qo_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .sample_first  (rsp_sample_first),
      .sample_second (rsp_sample_second),
      .second_valid  (rsp_second_valid),
      .last          (rsp_last)
   );

endmodule
`default_nettype wire

### hdl/gnb_checker.sv
// port-level checks for the gaussian noise block, bound to the top level
`default_nettype none
module gnb_port_checks (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_push,
   input wire logic        req_full,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [15:0] rsp_sample_first,
   input wire logic [15:0] rsp_sample_second
);

   // reset leaves no result and an open request side
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("result or full after reset");

   // front end is busy right after taking a request beat
   a_busy_after_push: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> req_full)
      else $error("request side not busy after a beat");

   // a waiting result holds until taken
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
      (!rsp_empty && $stable(rsp_sample_first) && $stable(rsp_sample_second)))
      else $error("waiting result changed");

endmodule

bind gaussian_noise_box_muller_lcg gnb_port_checks u_gnb_checker (
   .clock             (clock),
   .reset             (reset),
   .req_push          (req_push),
   .req_full          (req_full),
   .rsp_empty         (rsp_empty),
   .rsp_pop           (rsp_pop),
   .rsp_sample_first  (rsp_sample_first),
   .rsp_sample_second (rsp_sample_second)
);
`default_nettype wire
